FILE: src/cpec_pkg.sv
// Shared widths, constants and pipeline payload types for the circle pair collision block.
package cpec_pkg;

    localparam int POS_W  = 16;
    localparam int SPD_W  = 10;
    localparam int RAD_W  = 8;
    localparam int M_W    = 2 * RAD_W;
    localparam int NUM_W  = 28;
    localparam int DEN_W  = 18;
    localparam int Q_W    = 11;
    localparam int IN_W   = 104;
    localparam int OUT_W  = 56;

    localparam logic signed [SPD_W+1:0] SPD_MAX = 12'sd511;
    localparam logic signed [SPD_W+1:0] SPD_MIN = -12'sd512;
    localparam logic [Q_W-1:0]          Q_LIMIT = 11'd1536;

    // Payload leaving the front stages
    typedef struct packed {
        logic                     hit;
        logic                     ms_zero;
        logic                     neg1;
        logic                     neg2;
        logic [NUM_W-1:0]         mag1;
        logic [NUM_W-1:0]         mag2;
        logic [DEN_W-1:0]         den;
        logic signed [SPD_W-1:0]  u1;
        logic signed [SPD_W-1:0]  u2;
        logic signed [POS_W-1:0]  nax;
        logic signed [POS_W-1:0]  nbx;
    } front_t;

    // Payload carried beside the dividers
    typedef struct packed {
        logic                     hit;
        logic                     ms_zero;
        logic                     neg1;
        logic                     neg2;
        logic signed [SPD_W-1:0]  u1;
        logic signed [SPD_W-1:0]  u2;
        logic signed [POS_W-1:0]  nax;
        logic signed [POS_W-1:0]  nbx;
    } side_t;

endpackage

FILE: src/cpec_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
module cpec_divider (
    input  logic                       clk,
    input  logic                       en,
    input  logic [cpec_pkg::NUM_W-1:0] num,
    input  logic [cpec_pkg::DEN_W-1:0] den,
    output logic [cpec_pkg::Q_W-1:0]   quot
);
    import cpec_pkg::*;

    logic [NUM_W-1:0] rem_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   q_reg   [Q_W];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        localparam int B = Q_W - 1 - k;
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   q_in;
        logic [NUM_W:0]   trial;
        logic             take;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        // Try subtracting the shifted divisor for this bit
        assign trial = (NUM_W+1)'(den_in) << B;
        assign take  = {1'b0, rem_in} >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? rem_in - trial[NUM_W-1:0] : rem_in;
                den_reg[k] <= den_in;
                q_reg[k]   <= q_in | (take ? (Q_W'(1) << B) : '0);
            end
        end
    end

    assign quot = q_reg[Q_W-1];

endmodule

FILE: src/cpec_front.sv
// Front stages: distances, masses, hit test, numerators and overlap push.
module cpec_front #(
    parameter int POS_FRAC_BITS = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [cpec_pkg::IN_W-1:0]  in_data,
    output logic                       out_valid,
    output cpec_pkg::front_t           out_item
);
    import cpec_pkg::*;

    localparam int LIM_W = RAD_W + 1 + POS_FRAC_BITS;
    localparam int CW    = (LIM_W > POS_W + 1) ? LIM_W : POS_W + 1;
    localparam int PW    = CW + 2;
    localparam int SQ_W  = (2 * LIM_W > 2 * POS_W + 3) ? 2 * LIM_W : 2 * POS_W + 3;

    // Unpack the request
    logic signed [POS_W-1:0] ax, ay, bx, by;
    logic [RAD_W-1:0]        ar, br;
    logic signed [SPD_W-1:0] au, bu;

    assign ax = in_data[15:0];
    assign ay = in_data[31:16];
    assign ar = in_data[39:32];
    assign au = in_data[49:40];
    assign bx = in_data[65:50];
    assign by = in_data[81:66];
    assign br = in_data[89:82];
    assign bu = in_data[99:90];

    // Stage 1: differences, contact distance, masses
    logic                    v1_reg;
    logic signed [POS_W:0]   dx1_reg, dy1_reg;
    logic [LIM_W-1:0]        lim1_reg;
    logic [M_W-1:0]          m1_reg, m2_reg;
    logic signed [SPD_W-1:0] u1_1_reg, u2_1_reg;
    logic signed [POS_W-1:0] ax1_reg, bx1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg  <= $signed({bx[POS_W-1], bx}) - $signed({ax[POS_W-1], ax});
            dy1_reg  <= $signed({by[POS_W-1], by}) - $signed({ay[POS_W-1], ay});
            lim1_reg <= LIM_W'({1'b0, ar} + {1'b0, br}) << POS_FRAC_BITS;
            m1_reg   <= ar * ar;
            m2_reg   <= br * br;
            u1_1_reg <= au;
            u2_1_reg <= bu;
            ax1_reg  <= ax;
            bx1_reg  <= bx;
        end
    end

    // Stage 2: squares, numerator products, push candidate
    logic signed [M_W:0]     md, md_n;
    logic [CW-1:0]           ad, lim_c;
    logic                    push;
    logic [CW-1:0]           ov;
    logic signed [PW-1:0]    ax_w, bx_w, nax_w, nbx_w;
    logic signed [POS_W-1:0] nax_next, nbx_next;

    always_comb
    begin
        md    = $signed({1'b0, m1_reg}) - $signed({1'b0, m2_reg});
        md_n  = $signed({1'b0, m2_reg}) - $signed({1'b0, m1_reg});
        ad    = CW'(dx1_reg[POS_W] ? -dx1_reg : dx1_reg);
        lim_c = CW'(lim1_reg);
        push  = (ad != '0) && (ad < lim_c);
        ov    = push ? ((lim_c - ad) >> 1) : '0;
        ax_w  = PW'(ax1_reg);
        bx_w  = PW'(bx1_reg);
        if (dx1_reg > 0)
        begin
            nax_w = ax_w - $signed({2'b00, ov});
            nbx_w = bx_w + $signed({2'b00, ov});
        end
        else
        begin
            nax_w = ax_w + $signed({2'b00, ov});
            nbx_w = bx_w - $signed({2'b00, ov});
        end
        // Saturate to the position range
        if (nax_w > PW'(32767))
            nax_next = 16'sh7FFF;
        else if (nax_w < -PW'(32768))
            nax_next = -16'sh8000;
        else
            nax_next = nax_w[POS_W-1:0];
        if (nbx_w > PW'(32767))
            nbx_next = 16'sh7FFF;
        else if (nbx_w < -PW'(32768))
            nbx_next = -16'sh8000;
        else
            nbx_next = nbx_w[POS_W-1:0];
    end

    logic                    v2_reg;
    logic signed [2*POS_W+1:0] dxsq_reg, dysq_reg;
    logic [2*LIM_W-1:0]      lim2_reg;
    logic signed [M_W+SPD_W:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic [M_W:0]            ms2_reg;
    logic signed [SPD_W-1:0] u1_2_reg, u2_2_reg;
    logic signed [POS_W-1:0] ax2_reg, bx2_reg, pa2_reg, pb2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxsq_reg <= dx1_reg * dx1_reg;
            dysq_reg <= dy1_reg * dy1_reg;
            lim2_reg <= lim1_reg * lim1_reg;
            p1_reg   <= md * u1_1_reg;
            p2_reg   <= $signed({1'b0, m2_reg}) * u2_1_reg;
            p3_reg   <= md_n * u2_1_reg;
            p4_reg   <= $signed({1'b0, m1_reg}) * u1_1_reg;
            ms2_reg  <= {1'b0, m1_reg} + {1'b0, m2_reg};
            u1_2_reg <= u1_1_reg;
            u2_2_reg <= u2_1_reg;
            ax2_reg  <= ax1_reg;
            bx2_reg  <= bx1_reg;
            pa2_reg  <= nax_next;
            pb2_reg  <= nbx_next;
        end
    end

    // Stage 3: hit compare, numerator sums and magnitudes
    logic [SQ_W-1:0]           dsum;
    logic                      hit_next;
    logic signed [M_W+SPD_W+2:0] n1, n2;
    front_t                    item_next;
    front_t                    item_reg;
    logic                      v3_reg;

    always_comb
    begin
        dsum     = SQ_W'(dxsq_reg[2*POS_W:0]) + SQ_W'(dysq_reg[2*POS_W:0]);
        hit_next = dsum <= SQ_W'(lim2_reg);
        n1       = (M_W+SPD_W+3)'(p1_reg) + ((M_W+SPD_W+3)'(p2_reg) <<< 1);
        n2       = (M_W+SPD_W+3)'(p3_reg) + ((M_W+SPD_W+3)'(p4_reg) <<< 1);
        item_next.hit     = hit_next;
        item_next.ms_zero = (ms2_reg == '0);
        item_next.neg1    = n1[M_W+SPD_W+2];
        item_next.neg2    = n2[M_W+SPD_W+2];
        item_next.mag1    = NUM_W'(n1[M_W+SPD_W+2] ? -n1 : n1);
        item_next.mag2    = NUM_W'(n2[M_W+SPD_W+2] ? -n2 : n2);
        item_next.den     = DEN_W'(ms2_reg);
        item_next.u1      = u1_2_reg;
        item_next.u2      = u2_2_reg;
        item_next.nax     = hit_next ? pa2_reg : ax2_reg;
        item_next.nbx     = hit_next ? pb2_reg : bx2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item_reg;

endmodule

FILE: src/circle_pair_elastic_collision.sv
// Pipeline: 3 front stages, 11 divider stages and 1 output register from an accepted request to its result.
// Throughput: one pair per cycle while the output is not stalled; the two 11-stage quotient pipelines set the depth.
// A stall at the output freezes every stage together, so nothing is lost or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits; payload registers are not reset.
module circle_pair_elastic_collision #(
    parameter int POS_FRAC_BITS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // first_x, first_y, first_radius, first_speed,
    // second_x, second_y, second_radius, second_speed, zero pad
    input  logic [cpec_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // hit, first_speed_out, second_speed_out, first_x_out, second_x_out, zero pad
    output logic [cpec_pkg::OUT_W-1:0]  m_axis_tdata
);
    import cpec_pkg::*;

    logic   advance;
    logic   front_valid;
    front_t front_item;

    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    cpec_front #(
        .POS_FRAC_BITS(POS_FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (s_axis_tvalid),
        .in_data  (s_axis_tdata),
        .out_valid(front_valid),
        .out_item (front_item)
    );

    logic [Q_W-1:0] q1, q2;

    cpec_divider u_div1 (
        .clk (clk),
        .en  (advance),
        .num (front_item.mag1),
        .den (front_item.den),
        .quot(q1)
    );

    cpec_divider u_div2 (
        .clk (clk),
        .en  (advance),
        .num (front_item.mag2),
        .den (front_item.den),
        .quot(q2)
    );

    // Carry the side payload beside the dividers
    side_t side_reg  [Q_W];
    logic  valid_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_side
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    side_reg[k].hit     <= front_item.hit;
                    side_reg[k].ms_zero <= front_item.ms_zero;
                    side_reg[k].neg1    <= front_item.neg1;
                    side_reg[k].neg2    <= front_item.neg2;
                    side_reg[k].u1      <= front_item.u1;
                    side_reg[k].u2      <= front_item.u2;
                    side_reg[k].nax     <= front_item.nax;
                    side_reg[k].nbx     <= front_item.nbx;
                end
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else if (advance)
                    valid_reg[k] <= front_valid;
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (advance)
                    side_reg[k] <= side_reg[k-1];
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else if (advance)
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Apply signs, saturate and pick pass-through speeds
    side_t                   last;
    logic signed [SPD_W+1:0] s1, s2;
    logic signed [SPD_W-1:0] v1_next, v2_next;
    logic [OUT_W-1:0]        data_next;
    logic [OUT_W-1:0]        data_reg;
    logic                    out_valid_reg;

    always_comb
    begin
        last = side_reg[Q_W-1];
        s1   = last.neg1 ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
        s2   = last.neg2 ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
        if (s1 > SPD_MAX)
            v1_next = SPD_MAX[SPD_W-1:0];
        else if (s1 < SPD_MIN)
            v1_next = SPD_MIN[SPD_W-1:0];
        else
            v1_next = s1[SPD_W-1:0];
        if (s2 > SPD_MAX)
            v2_next = SPD_MAX[SPD_W-1:0];
        else if (s2 < SPD_MIN)
            v2_next = SPD_MIN[SPD_W-1:0];
        else
            v2_next = s2[SPD_W-1:0];
        if (!last.hit || last.ms_zero)
        begin
            v1_next = last.u1;
            v2_next = last.u2;
        end
        data_next = {3'b000, last.nbx, last.nax, v2_next, v1_next, last.hit};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= valid_reg[Q_W-1];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = data_reg;

    // A valid last divider stage shows as a result after the next advance
    a_valid_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance && valid_reg[Q_W-1] |=> m_axis_tvalid)
        else $error("valid item lost before the output register");

    // Quotient magnitudes stay below three times the largest speed magnitude
    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[Q_W-1] && side_reg[Q_W-1].hit && !side_reg[Q_W-1].ms_zero
        |-> (q1 < Q_LIMIT) && (q2 < Q_LIMIT))
        else $error("quotient out of expected range");

    // Without a hit both speeds pass through
    a_no_hit_pass: assert property (@(posedge clk) disable iff (!rst_n)
        advance && valid_reg[Q_W-1] && !side_reg[Q_W-1].hit
        |=> (m_axis_tdata[10:1] == $past(side_reg[Q_W-1].u1))
            && (m_axis_tdata[20:11] == $past(side_reg[Q_W-1].u2)))
        else $error("speeds changed without a hit");

endmodule

FILE: dv/tb.sv
// Testbench for circle_pair_elastic_collision: random and directed pairs checked against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpec_pkg::*;

    localparam int FRAC = 4;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic [7:0]         ar;
        logic signed [9:0]  au;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic [7:0]         br;
        logic signed [9:0]  bu;
    } pair_t;

    typedef struct packed {
        logic               hit;
        logic signed [9:0]  v1;
        logic signed [9:0]  v2;
        logic signed [15:0] nax;
        logic signed [15:0] nbx;
    } bounce_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_W-1:0]    m_axis_tdata;

    bounce_t bounce_q[$];
    int      error_count;
    bit      calm;

    circle_pair_elastic_collision #(.POS_FRAC_BITS(FRAC)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    // Compute the expected collision outcome for one pair
    function automatic bounce_t predict_bounce(pair_t p);
        bounce_t   r;
        longint    dx, dy, lim, m1, m2, ms, v1, v2, nax, nbx, sep, ov;
        dx  = longint'(p.bx) - longint'(p.ax);
        dy  = longint'(p.by) - longint'(p.ay);
        lim = (longint'(p.ar) + longint'(p.br)) * (64'sd1 << FRAC);
        r.hit = (dx * dx + dy * dy) <= lim * lim;
        v1 = p.au; v2 = p.bu; nax = p.ax; nbx = p.bx;
        if (r.hit) begin
            m1 = longint'(p.ar) * longint'(p.ar);
            m2 = longint'(p.br) * longint'(p.br);
            ms = m1 + m2;
            if (ms != 0) begin
                v1 = ((m1 - m2) * longint'(p.au) + 2 * m2 * longint'(p.bu)) / ms;
                v2 = ((m2 - m1) * longint'(p.bu) + 2 * m1 * longint'(p.au)) / ms;
                v1 = v1 < -512 ? -512 : (v1 > 511 ? 511 : v1);
                v2 = v2 < -512 ? -512 : (v2 > 511 ? 511 : v2);
            end
            sep = dx < 0 ? -dx : dx;
            if (sep > 0 && sep < lim) begin
                ov = (lim - sep) / 2;
                if (dx > 0) begin
                    nax = nax - ov;
                    nbx = nbx + ov;
                end
                else begin
                    nax = nax + ov;
                    nbx = nbx - ov;
                end
                nax = nax < -32768 ? -32768 : (nax > 32767 ? 32767 : nax);
                nbx = nbx < -32768 ? -32768 : (nbx > 32767 ? 32767 : nbx);
            end
        end
        r.v1 = v1[9:0]; r.v2 = v2[9:0]; r.nax = nax[15:0]; r.nbx = nbx[15:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Send one request, with an optional random gap first
    task automatic send_pair(pair_t p);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {p.bu, p.br, p.by, p.bx, p.au, p.ar, p.ay, p.ax};
        s_axis_tvalid <= 1'b1;
        bounce_q.insert(bounce_q.size(), predict_bounce(p));
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Check each accepted result against the oldest prediction
    always @(posedge clk) begin
        bounce_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[0], m_axis_tdata[10:1], m_axis_tdata[20:11],
                   m_axis_tdata[36:21], m_axis_tdata[52:37]};
            if (bounce_q.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end
            else begin
                want = bounce_q.pop_front();
                if (got.hit != want.hit) report_mismatch("hit", got.hit, want.hit);
                if (got.v1 != want.v1) report_mismatch("first_speed_out", got.v1, want.v1);
                if (got.v2 != want.v2) report_mismatch("second_speed_out", got.v2, want.v2);
                if (got.nax != want.nax) report_mismatch("first_x_out", got.nax, want.nax);
                if (got.nbx != want.nbx) report_mismatch("second_x_out", got.nbx, want.nbx);
            end
        end
    end

    // Stall the result side in random bursts
    initial begin
        int burst;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 16);
                m_axis_tready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    function automatic pair_t random_pair();
        pair_t p;
        p = '0;
        p.ax = 16'($urandom); p.ay = 16'($urandom);
        p.bx = 16'($urandom); p.by = 16'($urandom);
        p.ar = 8'($urandom); p.br = 8'($urandom);
        p.au = 10'($urandom); p.bu = 10'($urandom);
        return p;
    endfunction

    // Pair placed near the first circle so most requests collide
    function automatic pair_t close_pair();
        pair_t p;
        int span;
        p = random_pair();
        if ($urandom_range(0, 3) == 0) begin
            p.ar = 8'($urandom_range(0, 8));
            p.br = 8'($urandom_range(0, 8));
        end
        span = (int'(p.ar) + int'(p.br)) * 16 + 8;
        p.bx = 16'(int'(p.ax) + int'($urandom_range(0, 2 * span)) - span);
        p.by = 16'(int'(p.ay) + int'($urandom_range(0, 2 * span)) - span);
        if ($urandom_range(0, 7) == 0) p.by = p.ay;
        if ($urandom_range(0, 7) == 0) p.bx = p.ax;
        return p;
    endfunction

    task automatic test_directed();
        pair_t p;
        p = '0; send_pair(p);
        p = '0; p.ar = 10; p.br = 10; p.au = 511; p.bu = -512; send_pair(p);
        p = '0; p.ar = 255; p.br = 255; p.au = -512; p.bu = 511;
        p.bx = 100; send_pair(p);
        p.bx = -100; send_pair(p);
        p = '0; p.ar = 255; p.br = 1; p.au = 511; p.bu = -512; p.bx = 16; send_pair(p);
        p = '0; p.ar = 1; p.br = 255; p.au = 511; p.bu = -512; p.bx = 16; send_pair(p);
        p = '0; p.ar = 255; p.br = 255; p.ax = 16'sh7FF0; p.bx = 16'sh7FFF; send_pair(p);
        p = '0; p.ar = 255; p.br = 255; p.ax = -16'sh8000; p.bx = -16'sh7FF0; send_pair(p);
        p = '0; p.ax = -16'sh8000; p.ay = -16'sh8000; p.bx = 16'sh7FFF; p.by = 16'sh7FFF;
        p.ar = 255; p.br = 255; p.au = 511; p.bu = 511; send_pair(p);
        p = '0; p.ar = 1; p.br = 1; p.bx = 32; send_pair(p);
        p.bx = 33; send_pair(p);
        p = '0; p.ar = 5; p.br = 5; p.by = 50; p.au = 7; p.bu = -3; send_pair(p);
        p = '0; p.ar = 0; p.br = 3; p.bx = 8; p.au = 100; p.bu = 20; send_pair(p);
        p = '0; p.ar = 8'hFF; p.br = 8'hFF; p.ax = 16'hFFFF; p.ay = 16'hFFFF;
        p.au = 10'h3FF; p.bu = 10'h3FF; send_pair(p);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_pair($urandom_range(0, 4) == 0 ? random_pair() : close_pair());
    endtask

    task automatic test_full_rate(int count);
        calm = 1'b1;
        test_random(count);
    endtask

    initial begin
        int wait_cycles;
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        error_count = 0;
        calm = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(550);
        test_full_rate(150);
        s_axis_tvalid <= 1'b0;
        wait_cycles = 0;
        while (bounce_q.size() != 0 && wait_cycles < 5000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (30) @(posedge clk);
        if (error_count == 0 && bounce_q.size() == 0)
            $display("circle_pair_elastic_collision verification clean");
        else
            $display("circle_pair_elastic_collision verification failed");
        $finish;
    end

    // Bound the run
    initial begin
        #2ms;
        $display("circle_pair_elastic_collision verification failed");
        $finish;
    end
endmodule
